// ===== design/asbfd_pkg.sv =====
// Shared types, constants and helpers for the access splitter.
// Used by every file of the block; depends on nothing.
package asbfd_pkg;

   // field widths
   localparam int OFF_W        = 48;
   localparam int LEN_W        = 31;
   localparam int SLOT_W       = 32;
   localparam int CNT_W        = 7;
   localparam int RANK_FIELD_W = 6;
   localparam int IDX_FIELD_W  = 6;
   localparam int FUNC_W       = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 48;

   // default sizes
   localparam int MAX_DOMAINS_DEF = 64;
   localparam int MAX_RANKS_DEF   = 64;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SPLIT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_END      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_COUNT = 2'd3;

   // index width for a table of the given depth
   function automatic int idx_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_END,
      ST_CLIP,
      ST_LEN,
      ST_EMIT
   } asbfd_state_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic calc_end;
      logic calc_clip;
      logic calc_len;
      logic emit;
   } asbfd_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              len_zero;
      logic              pre_bad;
      logic              div_done;
      logic              out_free;
      logic              item_done;
   } asbfd_status_type;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [IDX_FIELD_W-1:0] map_index;
      logic [RANK_FIELD_W-1:0] map_rank;
      logic [OFF_W-1:0]       access_offset;
      logic [LEN_W-1:0]       access_length;
   } asbfd_req_type;

   typedef struct packed {
      logic [RANK_FIELD_W-1:0] rank;
      logic [OFF_W-1:0]        piece_offset;
      logic [LEN_W-1:0]        piece_length;
      logic [SLOT_W-1:0]       slot;
      logic [OFF_W-1:0]        first_buffer_index;
      logic [CNT_W-1:0]        ranks_in_use;
      logic                    last;
      logic                    error;
   } asbfd_rsp_type;

endpackage

// ===== design/asbfd_if.sv =====
// Request and result channel interfaces of the access splitter.
// Depends on asbfd_pkg for field widths.
interface asbfd_req_if;
   import asbfd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [IDX_FIELD_W-1:0]  map_index;
   logic [RANK_FIELD_W-1:0] map_rank;
   logic [OFF_W-1:0]        access_offset;
   logic [LEN_W-1:0]        access_length;

   modport source (output valid, func, map_index, map_rank, access_offset, access_length,
                   input ready);
   modport sink   (input valid, func, map_index, map_rank, access_offset, access_length,
                   output ready);
endinterface

interface asbfd_rsp_if;
   import asbfd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [RANK_FIELD_W-1:0] rank;
   logic [OFF_W-1:0]        piece_offset;
   logic [LEN_W-1:0]        piece_length;
   logic [SLOT_W-1:0]       slot;
   logic [OFF_W-1:0]        first_buffer_index;
   logic [CNT_W-1:0]        ranks_in_use;
   logic                    last;
   logic                    error;

   modport source (output valid, rank, piece_offset, piece_length, slot, first_buffer_index,
                          ranks_in_use, last, error,
                   input ready);
   modport sink   (input valid, rank, piece_offset, piece_length, slot, first_buffer_index,
                         ranks_in_use, last, error,
                   output ready);
endinterface

// ===== design/asbfd_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the domain index.
// Depends on asbfd_pkg for the offset width.
module asbfd_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [asbfd_pkg::OFF_W-1:0]  dividend,
   input  logic [asbfd_pkg::OFF_W-1:0]  divisor,
   output logic [asbfd_pkg::OFF_W-1:0]  quotient,
   output logic [asbfd_pkg::OFF_W-1:0]  remainder,
   output logic                         done
);
   import asbfd_pkg::*;

   localparam int STEP_W = $clog2(OFF_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OFF_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [OFF_W-1:0]  quo_ff, quo_in;
   logic [OFF_W-1:0]  rmd_ff, rmd_in;
   logic [OFF_W-1:0]  dsr_ff, dsr_in;
   logic [OFF_W:0]    rmd_shift;
   logic [OFF_W:0]    rmd_sub;

   // shift in the next dividend bit and try the subtract
   assign rmd_shift = {rmd_ff, quo_ff[OFF_W-1]};
   assign rmd_sub   = rmd_shift - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rmd_in  = rmd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rmd_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (rmd_shift >= {1'b0, dsr_ff}) begin
            rmd_in = rmd_sub[OFF_W-1:0];
            quo_in = {quo_ff[OFF_W-2:0], 1'b1};
         end else begin
            rmd_in = rmd_shift[OFF_W-1:0];
            quo_in = {quo_ff[OFF_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rmd_ff <= rmd_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rmd_ff;
   assign done      = done_ff;

endmodule

// ===== design/asbfd_datapath.sv =====
// Datapath of the access splitter: configuration, rank map, per-rank tallies,
// piece arithmetic and the result register. Depends on asbfd_pkg, asbfd_divider.
module asbfd_datapath #(
   parameter int MAX_DOMAINS = asbfd_pkg::MAX_DOMAINS_DEF,
   parameter int MAX_RANKS   = asbfd_pkg::MAX_RANKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [asbfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asbfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  asbfd_pkg::asbfd_req_type          req_item,
   input  logic                              rsp_ready,
   input  asbfd_pkg::asbfd_cmd_type          cmd,
   output asbfd_pkg::asbfd_status_type       status,
   output logic                              rsp_valid,
   output asbfd_pkg::asbfd_rsp_type          rsp_item
);
   import asbfd_pkg::*;

   localparam int DOM_W  = idx_width(MAX_DOMAINS);
   localparam int RANK_W = idx_width(MAX_RANKS);
   localparam int TAL_W  = SLOT_W + OFF_W;

   // configuration
   logic [OFF_W-1:0] min_off_ff, min_off_in;
   logic [OFF_W-1:0] dsize_ff, dsize_in;
   logic [OFF_W-1:0] max_end_ff, max_end_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;

   // piece walk
   logic [OFF_W-1:0] off_ff, off_in;
   logic             wrap_ff, wrap_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] npiece_ff, npiece_in;
   logic             bad_ff, bad_in;
   logic             kbad_ff, kbad_in;
   logic [OFF_W-1:0] base_ff, base_in;
   logic [OFF_W-1:0] end_ff, end_in;
   logic [LEN_W-1:0] len_ff, len_in;

   // per-rank tallies
   logic [MAX_RANKS-1:0] fiv_ff, fiv_in;
   logic [OFF_W-1:0]     buf_pos_ff, buf_pos_in;
   logic [CNT_W-1:0]     active_ff, active_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   asbfd_rsp_type rsp_item_ff, rsp_item_in;

   // memories
   logic [RANK_W-1:0] rank_map_mem [MAX_DOMAINS];
   logic [TAL_W-1:0]  tally_mem [MAX_RANKS];
   logic [RANK_W-1:0] map_q_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [TAL_W-1:0]  tally_q_ff;

   // combinational terms
   logic              pre_bad;
   logic [OFF_W-1:0]  div_dividend;
   logic              div_start;
   logic [OFF_W-1:0]  div_quo;
   logic [OFF_W-1:0]  div_rmd;
   logic              div_done;
   logic [CNT_W-1:0]  limit;
   logic              kbad;
   logic [OFF_W:0]    end_raw;
   logic [OFF_W-1:0]  end_clip;
   logic [OFF_W-1:0]  span;
   logic [OFF_W:0]    off_next;
   logic              map_we;
   logic [RANK_W-1:0] rank_sel;
   logic              emit_good;
   logic              rank_valid;
   logic [SLOT_W-1:0] slot_cur;
   logic [OFF_W-1:0]  fbi_cur;
   logic [CNT_W-1:0]  active_new;
   logic [LEN_W-1:0]  rem_new;
   logic              list_full;

   // write configuration registers
   always_comb begin
      min_off_in = min_off_ff;
      dsize_in   = dsize_ff;
      max_end_in = max_end_ff;
      dcount_in  = dcount_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_OFFSET:   min_off_in = csr_wdata[OFF_W-1:0];
            REG_DOMAIN_SIZE:  dsize_in   = csr_wdata[OFF_W-1:0];
            REG_MAX_END:      max_end_in = csr_wdata[OFF_W-1:0];
            REG_DOMAIN_COUNT: dcount_in  = csr_wdata[CNT_W-1:0];
         endcase
      end
   end

   // start check and domain index; a start past the top of the offset space is bad
   assign pre_bad      = wrap_ff || (off_ff < min_off_ff) || (dsize_ff == '0);
   assign div_dividend = off_ff - min_off_ff;
   assign div_start    = cmd.start && !pre_bad;

   asbfd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (dsize_ff),
      .quotient  (div_quo),
      .remainder (div_rmd),
      .done      (div_done)
   );

   assign limit = (dcount_ff < CNT_W'(MAX_DOMAINS)) ? dcount_ff : CNT_W'(MAX_DOMAINS);
   assign kbad  = div_quo >= {{(OFF_W-CNT_W){1'b0}}, limit};

   // domain end: start of domain plus size minus one, clipped to the range end
   assign end_raw  = {1'b0, base_ff} + {1'b0, dsize_ff} - {{OFF_W{1'b0}}, 1'b1};
   assign end_clip = (end_raw > {1'b0, max_end_ff}) ? max_end_ff : end_raw[OFF_W-1:0];
   assign span     = end_ff - off_ff;

   // next piece start, with the carry out of the offset width
   assign off_next = {1'b0, off_ff} + {{(OFF_W+1-LEN_W){1'b0}}, len_ff};

   // rank lookup, out-of-range ranks fold to zero
   assign rank_sel = (CNT_W'(map_q_ff) < CNT_W'(MAX_RANKS)) ? map_q_ff : '0;

   // piece bookkeeping
   assign emit_good  = cmd.emit && !bad_ff;
   assign rank_valid = fiv_ff[rank_ff];
   assign slot_cur   = rank_valid ? tally_q_ff[TAL_W-1:OFF_W] : '0;
   assign fbi_cur    = rank_valid ? tally_q_ff[OFF_W-1:0] : buf_pos_ff;
   assign active_new = rank_valid ? active_ff : active_ff + 1'b1;
   assign rem_new    = rem_ff - len_ff;
   assign list_full  = (npiece_ff == CNT_W'(MAX_DOMAINS - 1)) && (rem_new != '0);

   // advance the piece walk
   always_comb begin
      off_in    = off_ff;
      wrap_in   = wrap_ff;
      rem_in    = rem_ff;
      npiece_in = npiece_ff;
      bad_in    = bad_ff;
      kbad_in   = kbad_ff;
      base_in   = base_ff;
      end_in    = end_ff;
      len_in    = len_ff;
      if (cmd.accept) begin
         off_in    = req_item.access_offset;
         wrap_in   = 1'b0;
         rem_in    = req_item.access_length;
         npiece_in = '0;
      end
      if (cmd.start) begin
         bad_in = pre_bad;
      end
      if (cmd.calc_end) begin
         base_in = off_ff - div_rmd;
         kbad_in = kbad;
      end
      if (cmd.calc_clip) begin
         end_in = end_clip;
      end
      if (cmd.calc_len) begin
         bad_in = kbad_ff || (end_ff < off_ff);
         len_in = (span >= OFF_W'(rem_ff)) ? rem_ff : span[LEN_W-1:0] + 1'b1;
      end
      if (emit_good) begin
         off_in    = off_next[OFF_W-1:0];
         wrap_in   = off_next[OFF_W];
         rem_in    = rem_new;
         npiece_in = npiece_ff + 1'b1;
      end
   end

   // update tallies, drop them on a clear request
   always_comb begin
      fiv_in     = fiv_ff;
      buf_pos_in = buf_pos_ff;
      active_in  = active_ff;
      if (cmd.accept && (req_item.func == FUNC_CLEAR)) begin
         fiv_in     = '0;
         buf_pos_in = '0;
         active_in  = '0;
      end
      if (emit_good) begin
         fiv_in[rank_ff] = 1'b1;
         buf_pos_in      = buf_pos_ff + OFF_W'(len_ff);
         active_in       = active_new;
      end
   end

   // load the result register, hold it while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (bad_ff) begin
            rsp_item_in.rank               = '0;
            rsp_item_in.piece_offset       = off_ff;
            rsp_item_in.piece_length       = rem_ff;
            rsp_item_in.slot               = '0;
            rsp_item_in.first_buffer_index = '0;
            rsp_item_in.ranks_in_use       = active_ff;
            rsp_item_in.last               = 1'b1;
            rsp_item_in.error              = 1'b1;
         end else begin
            rsp_item_in.rank               = RANK_FIELD_W'(rank_ff);
            rsp_item_in.piece_offset       = off_ff;
            rsp_item_in.piece_length       = len_ff;
            rsp_item_in.slot               = slot_cur;
            rsp_item_in.first_buffer_index = fbi_cur;
            rsp_item_in.ranks_in_use       = active_new;
            rsp_item_in.last               = (rem_new == '0) || list_full;
            rsp_item_in.error              = list_full;
         end
      end
   end

   // rank map: write on a load request, read at the domain index
   assign map_we = cmd.accept && (req_item.func == FUNC_LOAD)
                   && (CNT_W'(req_item.map_index) < CNT_W'(MAX_DOMAINS))
                   && (CNT_W'(req_item.map_rank) < CNT_W'(MAX_RANKS));

   always_ff @(posedge clock) begin
      if (map_we) begin
         rank_map_mem[req_item.map_index[DOM_W-1:0]] <= req_item.map_rank[RANK_W-1:0];
      end
      if (cmd.calc_end) begin
         map_q_ff <= rank_map_mem[div_quo[DOM_W-1:0]];
      end
   end

   // tally memory: slot count and first buffer index per rank
   always_ff @(posedge clock) begin
      if (emit_good) begin
         tally_mem[rank_ff] <= {slot_cur + 1'b1, fbi_cur};
      end
      if (cmd.calc_clip) begin
         tally_q_ff <= tally_mem[rank_sel];
         rank_ff    <= rank_sel;
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_off_ff   <= '0;
         dsize_ff     <= OFF_W'(1);
         max_end_ff   <= '0;
         dcount_ff    <= CNT_W'(1);
         fiv_ff       <= '0;
         buf_pos_ff   <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_off_ff   <= min_off_in;
         dsize_ff     <= dsize_in;
         max_end_ff   <= max_end_in;
         dcount_ff    <= dcount_in;
         fiv_ff       <= fiv_in;
         buf_pos_ff   <= buf_pos_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      wrap_ff     <= wrap_in;
      rem_ff      <= rem_in;
      npiece_ff   <= npiece_in;
      bad_ff      <= bad_in;
      kbad_ff     <= kbad_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      len_ff      <= len_in;
      rsp_item_ff <= rsp_item_in;
   end

   // status to the controller
   always_comb begin
      status.func      = req_item.func;
      status.len_zero  = (req_item.access_length == '0);
      status.pre_bad   = pre_bad;
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.item_done = bad_ff || (rem_new == '0) || list_full;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== design/asbfd_ctrl.sv =====
// Controller state machine of the access splitter: sequences each piece.
// Depends on asbfd_pkg for the state type and command/status structs.
module asbfd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  asbfd_pkg::asbfd_status_type status,
   output asbfd_pkg::asbfd_cmd_type    cmd
);
   import asbfd_pkg::*;

   asbfd_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (status.func == FUNC_SPLIT) && !status.len_zero) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = status.pre_bad ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_END;
            end
         end
         ST_END:  state_in = ST_CLIP;
         ST_CLIP: state_in = ST_LEN;
         ST_LEN:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.item_done ? ST_IDLE : ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_START: cmd.start     = 1'b1;
         ST_DIV:   cmd           = '0;
         ST_END:   cmd.calc_end  = 1'b1;
         ST_CLIP:  cmd.calc_clip = 1'b1;
         ST_LEN:   cmd.calc_len  = 1'b1;
         ST_EMIT:  cmd.emit      = status.out_free;
         default:  cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/access_split_by_file_domain.sv =====
// Top level of the access splitter: controller plus datapath.
// Depends on asbfd_pkg, asbfd_if, asbfd_ctrl, asbfd_datapath.
//
//   port      | dir | handshake         | carries
//   ----------+-----+-------------------+--------------------------------------
//   req_chan  | in  | valid/ready       | func, map_index, map_rank, offset, len
//   rsp_chan  | out | valid/ready       | one piece (or error) per transfer
//   csr_*     | in  | write enable      | min offset, size, max end, count
//
// Load, clear, unused and zero-length requests are taken in the idle state alone. A split
// request is accepted, then each piece runs start, the 48-bit domain index divider (one
// bit a cycle plus done), end, clip, length and emit; a bad start goes straight to emit.
// Reset is synchronous; the rank map is not cleared and must be loaded.
// A stalled result holds in the output register; the next piece waits in
// its emit step, while a new request is taken once the split has finished.
module access_split_by_file_domain #(
   parameter int MAX_DOMAINS = asbfd_pkg::MAX_DOMAINS_DEF,
   parameter int MAX_RANKS   = asbfd_pkg::MAX_RANKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [asbfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asbfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   asbfd_req_if.sink                         req_chan,
   asbfd_rsp_if.source                       rsp_chan
);
   import asbfd_pkg::*;

   asbfd_req_type    req_item;
   asbfd_rsp_type    rsp_item;
   asbfd_cmd_type    cmd;
   asbfd_status_type status;
   logic             rsp_valid;

   // gather request fields
   assign req_item.func          = req_chan.func;
   assign req_item.map_index     = req_chan.map_index;
   assign req_item.map_rank      = req_chan.map_rank;
   assign req_item.access_offset = req_chan.access_offset;
   assign req_item.access_length = req_chan.access_length;

   asbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   asbfd_datapath #(
      .MAX_DOMAINS (MAX_DOMAINS),
      .MAX_RANKS   (MAX_RANKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // drive result fields
   assign rsp_chan.valid              = rsp_valid;
   assign rsp_chan.rank               = rsp_item.rank;
   assign rsp_chan.piece_offset       = rsp_item.piece_offset;
   assign rsp_chan.piece_length       = rsp_item.piece_length;
   assign rsp_chan.slot               = rsp_item.slot;
   assign rsp_chan.first_buffer_index = rsp_item.first_buffer_index;
   assign rsp_chan.ranks_in_use       = rsp_item.ranks_in_use;
   assign rsp_chan.last               = rsp_item.last;
   assign rsp_chan.error              = rsp_item.error;

endmodule

// ===== design/asbfd_checker.sv =====
// Port-level checks for the access splitter, bound to its top level.
// Depends on asbfd_pkg for the function codes.
module asbfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [asbfd_pkg::FUNC_W-1:0]    req_func,
   input logic [asbfd_pkg::LEN_W-1:0]     req_length,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [asbfd_pkg::OFF_W-1:0]     rsp_offset,
   input logic [asbfd_pkg::LEN_W-1:0]     rsp_length,
   input logic                            rsp_last,
   input logic                            rsp_error
);
   import asbfd_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_offset) && $stable(rsp_length)
                                  && $stable(rsp_last) && $stable(rsp_error))
      else $error("result payload changed while stalled");

   // a split request with bytes to place blocks the next request
   a_split_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_SPLIT) && (req_length != '0)
      |=> !req_ready)
      else $error("request taken while a split is in progress");

   // a zero-length split produces no result
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_SPLIT) && (req_length == '0)
      && !rsp_valid |=> !rsp_valid)
      else $error("result produced for a zero-length access");

endmodule

bind access_split_by_file_domain asbfd_checker u_asbfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_func   (req_chan.func),
   .req_length (req_chan.access_length),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_offset (rsp_chan.piece_offset),
   .rsp_length (rsp_chan.piece_length),
   .rsp_last   (rsp_chan.last),
   .rsp_error  (rsp_chan.error)
);
